>>> sv/plpid_pkg.sv
// ----------------------------------------------------------------------------
// plpid_pkg
// Shared types and constants of the preset lift PID controller.
// ----------------------------------------------------------------------------
package plpid_pkg;

  localparam int SEL_W      = 2;
  localparam int GAIN_W     = 16;
  localparam int PRESET_W   = 12;
  localparam int DBAND_W    = 8;
  localparam int WINDUP_W   = 15;
  localparam int DRIVE_W    = 8;
  localparam int PERR_W     = 16;
  localparam int LAST_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Q8.8 gains
  localparam int Q_FRAC     = 8;
  localparam int DRIVE_MAX  = 127;
  // integral term clamp in the drive sum is +-2^TERM_LIM_BIT
  localparam int TERM_LIM_BIT = 40;

  localparam logic [GAIN_W-1:0]   GAIN_P_RST    = 16'd512;
  localparam logic [GAIN_W-1:0]   GAIN_I_RST    = 16'd0;
  localparam logic [GAIN_W-1:0]   GAIN_D_RST    = 16'd512;
  localparam logic [PRESET_W-1:0] PRESET_1_RST  = 12'd150;
  localparam logic [PRESET_W-1:0] PRESET_2_RST  = 12'd200;
  localparam logic [PRESET_W-1:0] PRESET_3_RST  = 12'd400;
  localparam logic [DBAND_W-1:0]  DBAND_RST     = 8'd10;
  localparam logic [WINDUP_W-1:0] WINDUP_RST    = 15'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_PRESET_ONE,
    REG_PRESET_TWO,
    REG_PRESET_THREE,
    REG_DEAD_BAND,
    REG_WINDUP_LIMIT
  } cfg_reg_e;

  typedef enum logic [SEL_W-1:0] {
    SEL_HOME,
    SEL_ONE,
    SEL_TWO,
    SEL_THREE
  } height_sel_e;

endpackage

>>> sv/plpid_if.sv
// ----------------------------------------------------------------------------
// plpid_if
// Valid/ready channels of the preset lift PID controller.
// ----------------------------------------------------------------------------
interface plpid_in_if #(
  parameter int ENCODER_BITS = 16
) ();
  logic                           valid;
  logic                           ready;
  logic [plpid_pkg::SEL_W-1:0]    height_select;
  logic signed [ENCODER_BITS-1:0] encoder_count;

  modport source (output valid, height_select, encoder_count, input ready);
  modport sink   (input valid, height_select, encoder_count, output ready);
endinterface

interface plpid_out_if ();
  logic                               valid;
  logic                               ready;
  logic signed [plpid_pkg::DRIVE_W-1:0] drive_power;
  logic                               settled;
  logic signed [plpid_pkg::PERR_W-1:0]  position_error;

  modport source (output valid, drive_power, settled, position_error, input ready);
  modport sink   (input valid, drive_power, settled, position_error, output ready);
endinterface

interface plpid_cfg_if ();
  logic                                valid;
  logic                                ready;
  plpid_pkg::cfg_reg_e                 index;
  logic [plpid_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/preset_lift_pid_controller.sv
// ----------------------------------------------------------------------------
// preset_lift_pid_controller
// One tick in, one result out: a preset selector and an encoder reading are
// turned into a saturated motor command. The block takes one transaction per
// clock cycle unless the result side stalls it; a result passes through the
// input register, then the result register, before it is presented. That
// rate is set by the loop through the integral accumulator and the previous
// error, which are updated in the same cycle that computes the drive so the
// next tick sees them at once. Configuration writes are always accepted and
// must be issued while idle.
// ----------------------------------------------------------------------------
module preset_lift_pid_controller #(
  parameter int ENCODER_BITS = 16,
  parameter int SUM_BITS     = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  plpid_cfg_if.sink   cfg_i,
  plpid_in_if.sink    in_i,
  plpid_out_if.source out_o
);
  import plpid_pkg::*;

  localparam int ERR_W  = ((ENCODER_BITS > PRESET_W) ? ENCODER_BITS : PRESET_W) + 1;
  localparam int WC_W   = (ERR_W > WINDUP_W + 1) ? ERR_W : WINDUP_W + 1;
  localparam int ADD_W  = ((SUM_BITS > ERR_W) ? SUM_BITS : ERR_W) + 1;
  localparam int LW     = (ERR_W > LAST_W) ? ERR_W : LAST_W;
  localparam int PW     = (ERR_W > PERR_W) ? ERR_W : PERR_W;
  localparam int DW     = LW + 1;
  localparam int TERM_W = (SUM_BITS > TERM_LIM_BIT + 1) ? TERM_LIM_BIT + 2 : SUM_BITS;
  localparam int MW_A   = (ERR_W > TERM_W) ? ERR_W : TERM_W;
  localparam int MW     = (MW_A > DW) ? MW_A : DW;
  localparam int TOT_W  = MW + GAIN_W + 3;
  localparam logic signed [TOT_W-1:0] DRV_LIM  = TOT_W'(DRIVE_MAX);
  localparam logic signed [TOT_W-1:0] RND_BIAS = TOT_W'((1 << Q_FRAC) - 1);

  // configuration registers
  logic [GAIN_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
  logic [PRESET_W-1:0] preset_one_q, preset_two_q, preset_three_q;
  logic [DBAND_W-1:0]  dead_band_q;
  logic [WINDUP_W-1:0] windup_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= GAIN_P_RST;
      gain_i_q       <= GAIN_I_RST;
      gain_d_q       <= GAIN_D_RST;
      preset_one_q   <= PRESET_1_RST;
      preset_two_q   <= PRESET_2_RST;
      preset_three_q <= PRESET_3_RST;
      dead_band_q    <= DBAND_RST;
      windup_q       <= WINDUP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_GAIN_P:       gain_p_q       <= cfg_i.data;
        REG_GAIN_I:       gain_i_q       <= cfg_i.data;
        REG_GAIN_D:       gain_d_q       <= cfg_i.data;
        REG_PRESET_ONE:   preset_one_q   <= cfg_i.data[PRESET_W-1:0];
        REG_PRESET_TWO:   preset_two_q   <= cfg_i.data[PRESET_W-1:0];
        REG_PRESET_THREE: preset_three_q <= cfg_i.data[PRESET_W-1:0];
        REG_DEAD_BAND:    dead_band_q    <= cfg_i.data[DBAND_W-1:0];
        REG_WINDUP_LIMIT: windup_q       <= cfg_i.data[WINDUP_W-1:0];
      endcase
    end
  end

  // handshake: input register feeding the result register
  logic                    s0_valid_q;
  logic [SEL_W-1:0]        s0_sel_q;
  logic [ENCODER_BITS-1:0] s0_enc_q;
  logic                    out_valid_q;
  logic                    out_free, s0_fire, in_acc;

  assign out_free    = !out_valid_q || out_o.ready;
  assign s0_fire     = s0_valid_q && out_free;
  assign in_i.ready  = !s0_valid_q || out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s0_valid_q <= 1'b1;
      end else if (s0_fire) begin
        s0_valid_q <= 1'b0;
      end
      if (s0_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_sel_q <= in_i.height_select;
      s0_enc_q <= in_i.encoder_count;
    end
  end

  // controller state
  logic signed [SUM_BITS-1:0] error_sum_q, error_sum_d;
  logic signed [LAST_W-1:0]   last_error_q, last_error_d;

  // datapath
  logic [PRESET_W-1:0]        target;
  logic [ENCODER_BITS-1:0]    pos;
  logic signed [ERR_W-1:0]    err, dband_s;
  logic                       settled;
  logic signed [WC_W-1:0]     err_wc, windup_s;
  logic                       windup_hit;
  logic signed [ADD_W-1:0]    sum_add;
  logic [ADD_W-SUM_BITS:0]    sum_hi;
  logic signed [SUM_BITS-1:0] sum_sat;
  logic signed [LW-1:0]       err_lw;
  logic [LW-LAST_W:0]         last_hi;
  logic signed [DW-1:0]       deriv;
  logic signed [TERM_W-1:0]   term;
  logic signed [ERR_W+GAIN_W:0]  prod_p;
  logic signed [TERM_W+GAIN_W:0] prod_i;
  logic signed [DW+GAIN_W:0]     prod_d;
  logic signed [TOT_W-1:0]    total, bias, quot;
  logic signed [DRIVE_W-1:0]  drive;
  logic signed [PW-1:0]       err_pw;
  logic [PW-PERR_W:0]         perr_hi;
  logic signed [PERR_W-1:0]   perr;

  always_comb begin
    unique case (height_sel_e'(s0_sel_q))
      SEL_HOME:  target = '0;
      SEL_ONE:   target = preset_one_q;
      SEL_TWO:   target = preset_two_q;
      SEL_THREE: target = preset_three_q;
    endcase
  end

  // |encoder|; the most negative reading maps to 2^(N-1) as unsigned
  assign pos     = s0_enc_q[ENCODER_BITS-1] ? (~s0_enc_q + 1'b1) : s0_enc_q;
  assign err     = $signed(ERR_W'(target)) - $signed(ERR_W'(pos));
  assign dband_s = $signed(ERR_W'(dead_band_q));
  assign settled = (err <= dband_s) && (err >= -dband_s);

  assign err_wc     = WC_W'(err);
  assign windup_s   = $signed(WC_W'(windup_q));
  assign windup_hit = err_wc > windup_s;

  // integral: saturating add, then clear on zero error, overshoot or windup
  assign sum_add = ADD_W'(error_sum_q) + ADD_W'(err);
  assign sum_hi  = sum_add[ADD_W-1:SUM_BITS-1];

  always_comb begin
    if (sum_hi == '0 || sum_hi == '1) begin
      sum_sat = sum_add[SUM_BITS-1:0];
    end else begin
      sum_sat = sum_add[ADD_W-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                 : {1'b0, {(SUM_BITS-1){1'b1}}};
    end
    if (err == '0 || err[ERR_W-1] || windup_hit) begin
      error_sum_d = '0;
    end else begin
      error_sum_d = sum_sat;
    end
  end

  assign err_lw  = LW'(err);
  assign last_hi = err_lw[LW-1:LAST_W-1];

  always_comb begin
    if (last_hi == '0 || last_hi == '1) begin
      last_error_d = err_lw[LAST_W-1:0];
    end else begin
      last_error_d = err_lw[LW-1] ? {1'b1, {(LAST_W-1){1'b0}}}
                                  : {1'b0, {(LAST_W-1){1'b1}}};
    end
  end

  assign deriv = DW'(err) - DW'(last_error_q);

  generate
    if (SUM_BITS > TERM_LIM_BIT + 1) begin : g_term_clamp
      localparam logic signed [SUM_BITS-1:0] TLIM =
        SUM_BITS'(64'sh0000_0100_0000_0000);
      always_comb begin
        if (error_sum_d > TLIM) begin
          term = TERM_W'(TLIM);
        end else if (error_sum_d < -TLIM) begin
          term = TERM_W'(-TLIM);
        end else begin
          term = TERM_W'(error_sum_d);
        end
      end
    end else begin : g_term_pass
      assign term = error_sum_d;
    end
  endgenerate

  assign prod_p = err   * $signed({1'b0, gain_p_q});
  assign prod_i = term  * $signed({1'b0, gain_i_q});
  assign prod_d = deriv * $signed({1'b0, gain_d_q});
  assign total  = TOT_W'(prod_p) + TOT_W'(prod_i) + TOT_W'(prod_d);

  // Q8.8 to integer, truncating toward zero
  assign bias = total[TOT_W-1] ? RND_BIAS : '0;
  assign quot = (total + bias) >>> Q_FRAC;

  always_comb begin
    priority if (quot > DRV_LIM) begin
      drive = DRIVE_W'(DRIVE_MAX);
    end else if (quot < -DRV_LIM) begin
      drive = -DRIVE_W'(DRIVE_MAX);
    end else begin
      drive = quot[DRIVE_W-1:0];
    end
  end

  assign err_pw  = PW'(err);
  assign perr_hi = err_pw[PW-1:PERR_W-1];

  always_comb begin
    if (perr_hi == '0 || perr_hi == '1) begin
      perr = err_pw[PERR_W-1:0];
    end else begin
      perr = err_pw[PW-1] ? {1'b1, {(PERR_W-1){1'b0}}}
                          : {1'b0, {(PERR_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else if (s0_fire) begin
      if (settled) begin
        last_error_q <= '0;
      end else begin
        error_sum_q  <= error_sum_d;
        last_error_q <= last_error_d;
      end
    end
  end

  // result register
  logic signed [DRIVE_W-1:0] drive_q;
  logic                      settled_q;
  logic signed [PERR_W-1:0]  perr_q;

  always_ff @(posedge clk_i) begin
    if (s0_fire) begin
      drive_q   <= settled ? '0 : drive;
      settled_q <= settled;
      perr_q    <= settled ? '0 : perr;
    end
  end

  assign out_o.drive_power    = drive_q;
  assign out_o.settled        = settled_q;
  assign out_o.position_error = perr_q;

endmodule

>>> sv/plpid_checker.sv
// ----------------------------------------------------------------------------
// plpid_checker
// Port-level checks on the preset lift PID controller results.
// ----------------------------------------------------------------------------
module plpid_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] drive_power_i,
  input logic       settled_i,
  input logic [15:0] position_error_i
);

  // a settled result carries no drive and no error
  a_settled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && settled_i |-> drive_power_i == 8'h00 && position_error_i == 16'h0000)
    else $error("settled result with nonzero drive or error");

  // zero error always lies inside the deadband
  a_active_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !settled_i |-> position_error_i != 16'h0000)
    else $error("active result with zero position error");

  // drive saturates symmetrically, -128 is never produced
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> drive_power_i != 8'h80)
    else $error("drive power out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_power_i)
      && $stable(settled_i) && $stable(position_error_i))
    else $error("stalled result changed");

endmodule

bind preset_lift_pid_controller plpid_checker u_plpid_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .drive_power_i    (out_o.drive_power),
  .settled_i        (out_o.settled),
  .position_error_i (out_o.position_error)
);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the preset lift PID controller transaction by transaction. A
// scoreboard class keeps its own copy of the gains, presets, integral and
// previous error, works out the result of every accepted tick and compares
// each returned result field by field. Stimulus is a directed set of
// deadband, overshoot, saturation and windup cases, then random phases under
// several register settings, extremes included, with random idling on both
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import plpid_pkg::*;

  localparam int ENC_W       = 16;
  localparam int SUM_W       = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_TICKS = 200;
  localparam int NUM_PHASES  = 8;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      settled;
    logic signed [PERR_W-1:0]  perr;
  } drive_result_t;

  class drive_predictor;
    localparam longint SUM_HI   = 64'sh7FFF_FFFF;  // SUM_W = 32
    localparam longint SUM_LO   = -SUM_HI - 1;
    localparam longint LAST_HI  = 64'sd65535;
    localparam longint LAST_LO  = -64'sd65536;
    localparam longint TERM_CAP = 64'sd1 <<< TERM_LIM_BIT;

    longint gain_p, gain_i, gain_d;
    longint preset_one, preset_two, preset_three;
    longint dead_band, windup;
    longint integ, prev_err;
    drive_result_t awaited[$];
    int mismatches, checked, settled_cnt, ticks;

    function new();
      gain_p       = GAIN_P_RST;
      gain_i       = GAIN_I_RST;
      gain_d       = GAIN_D_RST;
      preset_one   = PRESET_1_RST;
      preset_two   = PRESET_2_RST;
      preset_three = PRESET_3_RST;
      dead_band    = DBAND_RST;
      windup       = WINDUP_RST;
      integ        = 0;
      prev_err     = 0;
      mismatches   = 0;
      checked      = 0;
      settled_cnt  = 0;
      ticks        = 0;
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_GAIN_P:       gain_p       = val[GAIN_W-1:0];
        REG_GAIN_I:       gain_i       = val[GAIN_W-1:0];
        REG_GAIN_D:       gain_d       = val[GAIN_W-1:0];
        REG_PRESET_ONE:   preset_one   = val[PRESET_W-1:0];
        REG_PRESET_TWO:   preset_two   = val[PRESET_W-1:0];
        REG_PRESET_THREE: preset_three = val[PRESET_W-1:0];
        REG_DEAD_BAND:    dead_band    = val[DBAND_W-1:0];
        REG_WINDUP_LIMIT: windup       = val[WINDUP_W-1:0];
      endcase
    endfunction

    function longint target_of(height_sel_e sel);
      case (sel)
        SEL_ONE:   return preset_one;
        SEL_TWO:   return preset_two;
        SEL_THREE: return preset_three;
        default:   return 0;
      endcase
    endfunction

    function void note_tick(height_sel_e sel, logic signed [ENC_W-1:0] enc);
      longint pos, tgt, err, slope, total, power;
      drive_result_t r;
      ticks++;
      pos = longint'(enc);
      if (pos < 0) pos = -pos;
      tgt = target_of(sel);
      if (pos >= tgt - dead_band && pos <= tgt + dead_band) begin
        // inside the window: integral is held, derivative history dropped
        prev_err = 0;
        settled_cnt++;
        r.drive   = '0;
        r.settled = 1'b1;
        r.perr    = '0;
        awaited.push_back(r);
        return;
      end
      err   = tgt - pos;
      integ = clip(integ + err, SUM_LO, SUM_HI);
      if (err == 0 || pos > tgt || err > windup) integ = 0;
      slope    = err - prev_err;
      prev_err = clip(err, LAST_LO, LAST_HI);
      total = err * gain_p + clip(integ, -TERM_CAP, TERM_CAP) * gain_i + slope * gain_d;
      // Q8.8 back to integer, truncating toward zero
      power = clip(total / (64'sd1 <<< Q_FRAC), -DRIVE_MAX, DRIVE_MAX);
      r.drive   = DRIVE_W'(power);
      r.settled = 1'b0;
      r.perr    = PERR_W'(clip(err, -64'sd32768, 64'sd32767));
      awaited.push_back(r);
    endfunction

    function void check_drive(drive_result_t got);
      drive_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        $error("result with no tick outstanding: drive_power %0d settled %0d position_error %0d",
               got.drive, got.settled, got.perr);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.drive !== want.drive) begin
        $error("drive_power: expected %0d, got %0d", want.drive, got.drive);
        mismatches++;
      end
      if (got.settled !== want.settled) begin
        $error("settled: expected %0d, got %0d", want.settled, got.settled);
        mismatches++;
      end
      if (got.perr !== want.perr) begin
        $error("position_error: expected %0d, got %0d", want.perr, got.perr);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  plpid_in_if #(.ENCODER_BITS(ENC_W)) tick_if ();
  plpid_out_if                        drive_if ();
  plpid_cfg_if                        cfg_if ();

  preset_lift_pid_controller #(
    .ENCODER_BITS(ENC_W),
    .SUM_BITS    (SUM_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .in_i  (tick_if),
    .out_o (drive_if)
  );

  drive_predictor tracker = new();

  int          cycle_cnt    = 0;
  int          settings_cnt = 0;
  bit          send_burst   = 1'b0;
  bit          take_burst   = 1'b0;
  bit          hold_done    = 1'b0;
  longint      walk_pos     = 0;
  height_sel_e cur_sel      = SEL_ONE;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_tick(height_sel_e sel, logic signed [ENC_W-1:0] enc);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_if.valid         <= 1'b1;
    tick_if.height_select <= sel;
    tick_if.encoder_count <= enc;
    do @(posedge clk); while (!tick_if.ready);
    tracker.note_tick(sel, enc);
  endtask

  // stop offering ticks until every outstanding result is back
  task automatic drain();
    @(negedge clk);
    tick_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                               logic [15:0] p1, logic [15:0] p2, logic [15:0] p3,
                               logic [15:0] db, logic [15:0] wl);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_PRESET_ONE, p1);
    write_reg(REG_PRESET_TWO, p2);
    write_reg(REG_PRESET_THREE, p3);
    write_reg(REG_DEAD_BAND, db);
    write_reg(REG_WINDUP_LIMIT, wl);
    settings_cnt++;
  endtask

  function automatic logic [15:0] rand_word(int narrow_max);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, narrow_max));
  endfunction

  // Mostly lift-like readings: a slow climb toward the target (builds up the
  // integral), jitter around the window edges, and the odd raw or extreme value.
  function automatic logic signed [ENC_W-1:0] pick_encoder(longint tgt, longint band);
    int          kind;
    longint      v;
    logic [15:0] raw;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      raw = 16'($urandom);
      return raw;
    end
    if (kind < 55) begin
      walk_pos += longint'($urandom_range(0, 12));
      if (walk_pos > tgt + band + 40) walk_pos = longint'($urandom_range(0, 40));
      v = walk_pos;
    end else if (kind < 85) begin
      v = tgt + longint'($urandom_range(0, 2 * band + 60)) - (band + 30);
    end else begin
      case ($urandom_range(0, 7))
        0:       v = tgt - band;
        1:       v = tgt - band - 1;
        2:       v = tgt + band;
        3:       v = tgt + band + 1;
        4:       v = 32767;
        5:       v = -32768;
        6:       v = 0;
        default: v = -1;
      endcase
    end
    if ($urandom_range(0, 9) == 0) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[ENC_W-1:0];
  endfunction

  // result side
  initial begin
    int            wait_n;
    drive_result_t got;
    drive_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      wait_n = take_burst ? 0 : $urandom_range(0, 8);
      // one long back-pressure stretch so the input side has to stall
      if (!hold_done && tracker.checked >= HOLD_AT) begin
        hold_done = 1'b1;
        wait_n    = HOLD_CYCLES;
      end
      @(negedge clk);
      if (wait_n > 0) begin
        drive_if.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      drive_if.ready <= 1'b1;
      do @(posedge clk); while (!drive_if.valid);
      got.drive   = drive_if.drive_power;
      got.settled = drive_if.settled;
      got.perr    = drive_if.position_error;
      tracker.check_drive(got);
    end
  end

  initial begin
    tick_if.valid         = 1'b0;
    tick_if.height_select = SEL_HOME;
    tick_if.encoder_count = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_GAIN_P;
    cfg_if.data           = '0;
    rst_n                 = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: window edges, overshoot, negative readings, saturation
    send_tick(SEL_HOME, 16'sd0);
    send_tick(SEL_HOME, 16'sd10);
    send_tick(SEL_HOME, -16'sd11);
    send_tick(SEL_ONE, 16'sd140);
    send_tick(SEL_ONE, 16'sd139);
    send_tick(SEL_ONE, 16'sd160);
    send_tick(SEL_ONE, -16'sd161);
    send_tick(SEL_TWO, 16'sd0);
    send_tick(SEL_TWO, 16'sd100);
    send_tick(SEL_TWO, -16'sd195);
    send_tick(SEL_THREE, 16'sd32767);
    send_tick(SEL_THREE, -16'sd32768);
    send_tick(SEL_THREE, -16'sd1);
    send_tick(SEL_HOME, 16'sd32767);
    send_tick(SEL_HOME, -16'sd32768);
    send_tick(SEL_THREE, 16'sd385);
    send_tick(SEL_THREE, 16'sd389);
    drain();

    // tight windup limit with integral gain: clear, accumulate, overshoot
    apply_setting(16'd64, 16'd256, 16'd32, 16'd150, 16'd200, 16'd400, 16'd2, 16'd20);
    send_tick(SEL_THREE, 16'sd300);
    send_tick(SEL_THREE, 16'sd390);
    send_tick(SEL_THREE, 16'sd392);
    send_tick(SEL_THREE, 16'sd395);
    send_tick(SEL_THREE, 16'sd410);
    send_tick(SEL_THREE, 16'sd399);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF);
        1: apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                         16'h0000, 16'h0000);
        2: apply_setting(16'd256, 16'd16, 16'd128, rand_word(4095), rand_word(4095),
                         rand_word(4095), 16'($urandom_range(0, 20)),
                         16'($urandom_range(0, 2000)));
        default: apply_setting(rand_word(1024), rand_word(64), rand_word(1024),
                               rand_word(4095), rand_word(4095), rand_word(4095),
                               rand_word(40), rand_word(3000));
      endcase
      walk_pos = 0;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (n == PHASE_TICKS / 2) drain();
        if ($urandom_range(0, 99) < 8) cur_sel = height_sel_e'($urandom_range(0, 3));
        send_tick(cur_sel, pick_encoder(tracker.target_of(cur_sel), tracker.dead_band));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("summary: %0d ticks (%0d settled) over %0d register settings",
             tracker.ticks, tracker.settled_cnt, settings_cnt + 1);
    $display("summary: %0d results checked, %0d field mismatches",
             tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/plpid_pkg.sv
sv/plpid_if.sv
sv/preset_lift_pid_controller.sv
sv/plpid_checker.sv
bench/tb_top.sv
